@@ rtl/core/imm_alu_pkg.sv @@
// Shared types and constants for the immediate ALU with status flags.
// Holds the request/response structs, status codes and opcode fields.
// No dependencies.
package imm_alu_pkg;

  typedef enum logic [1:0] {
    ExecOk         = 2'd0,
    ExecIllegal    = 2'd1,
    ExecPrivilege  = 2'd2,
    ExecNotHandled = 2'd3
  } exec_status_e;

  typedef enum logic [1:0] {
    SwNone  = 2'd0,
    SwUser  = 2'd1,
    SwSuper = 2'd2
  } stack_switch_e;

  typedef struct packed {
    logic [15:0] instruction_word;
    logic [31:0] immediate_value;
    logic [31:0] dest_value;
  } in_req_t;

  typedef struct packed {
    logic [31:0]   result_value;
    logic          write_result;
    exec_status_e  exec_status;
    logic [15:0]   sr_out;
    stack_switch_e stack_switch;
    logic [4:0]    base_cycles;
    logic          add_ea_cycles;
  } out_rsp_t;

  // Opcode groups (bits 15..12)
  localparam logic [3:0] GrpImm   = 4'h0;
  localparam logic [3:0] GrpQuick = 4'h5;

  // Group 0 operations (bits 11..8)
  localparam logic [3:0] OpOri    = 4'h0;
  localparam logic [3:0] OpAndi   = 4'h2;
  localparam logic [3:0] OpSubi   = 4'h4;
  localparam logic [3:0] OpAddi   = 4'h6;
  localparam logic [3:0] OpBitSt  = 4'h8;
  localparam logic [3:0] OpEori   = 4'hA;
  localparam logic [3:0] OpCmpi   = 4'hC;
  localparam logic [3:0] OpUnused = 4'hE;

  // Low byte of the CCR and SR forms
  localparam logic [7:0] LowCcr = 8'h3C;
  localparam logic [7:0] LowSr  = 8'h7C;

  localparam logic [1:0] SizeByte = 2'd0;
  localparam logic [1:0] SizeWord = 2'd1;
  localparam logic [1:0] SizeLong = 2'd2;
  localparam logic [1:0] SizeNone = 2'd3;

  localparam logic [2:0] ModeDataReg = 3'd0;
  localparam logic [2:0] ModeAddrReg = 3'd1;
  localparam logic [2:0] ModeSpecial = 3'd7;

  localparam logic [15:0] SrReset    = 16'h2700;
  localparam logic [15:0] SrImplMask = 16'hA71F;
  localparam logic [15:0] SrHighMask = 16'hFF00;
  localparam logic [4:0]  CcrMask    = 5'h1F;
  localparam int unsigned SrSBit = 13;
  localparam int unsigned CcrX   = 4;
  localparam int unsigned CcrN   = 3;
  localparam int unsigned CcrZ   = 2;
  localparam int unsigned CcrV   = 1;
  localparam int unsigned CcrC   = 0;

  localparam logic [4:0] Cyc4  = 5'd4;
  localparam logic [4:0] Cyc8  = 5'd8;
  localparam logic [4:0] Cyc12 = 5'd12;
  localparam logic [4:0] Cyc14 = 5'd14;
  localparam logic [4:0] Cyc16 = 5'd16;
  localparam logic [4:0] Cyc20 = 5'd20;

endpackage

@@ rtl/core/immediate_alu_with_status_flags_unit.sv @@
// Immediate/quick ALU execute stage with the held status register.
// Uses imm_alu_pkg for the request/response structs, codes and constants.
//
// The unit takes one request per clock and returns one response per request,
// passing through the input register, then one adder with flag logic, then
// the response register. SR is updated when a request leaves the execute
// register, so the next request already sees the new flags; requests never wait
// on one another. Back-pressure on the response side stalls the input only once
// both registers are full. After reset SR is 16'h2700 (supervisor, mask 7).
module immediate_alu_with_status_flags_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  imm_alu_pkg::in_req_t in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output imm_alu_pkg::out_rsp_t out_rsp_o
);

  logic                  s1_valid_q;
  imm_alu_pkg::in_req_t  s1_q;
  logic                  out_valid_q;
  imm_alu_pkg::out_rsp_t out_rsp_q;
  logic [15:0]           sr_q;

  logic                  out_adv;
  logic                  s1_load;
  logic                  in_accept;
  imm_alu_pkg::out_rsp_t rsp_d;
  logic [15:0]           sr_d;

  // Decode fields
  logic [15:0] op;
  logic [3:0]  grp;
  logic [3:0]  high;
  logic [1:0]  szf;
  logic [2:0]  mode;
  logic [2:0]  rg;
  logic [3:0]  q;
  logic        is_an;
  logic        lng;

  // Datapath
  logic [31:0] mask_sz;
  logic [31:0] mask_eff;
  logic [4:0]  msb_idx;
  logic [31:0] opa;
  logic [31:0] opb;
  logic        sub;
  logic [32:0] sum;
  logic [31:0] r_arith;
  logic [31:0] vvec;
  logic        c_flag;
  logic        v_flag;
  logic [31:0] r_logic;
  logic [4:0]  ccr_n;
  logic [15:0] sr_w;

  assign out_adv     = !out_valid_q || !out_stall_i;
  assign s1_load     = s1_valid_q && out_adv;
  assign in_stall_o  = s1_valid_q && !out_adv;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  assign op    = s1_q.instruction_word;
  assign grp   = op[15:12];
  assign high  = op[11:8];
  assign szf   = op[7:6];
  assign mode  = op[5:3];
  assign rg    = op[2:0];
  assign q     = {(op[11:9] == 3'd0), op[11:9]};
  assign is_an = (mode == imm_alu_pkg::ModeAddrReg);
  assign lng   = (szf == imm_alu_pkg::SizeLong);

  always_comb begin
    unique case (szf)
      imm_alu_pkg::SizeByte: begin
        mask_sz = 32'h0000_00FF;
        msb_idx = 5'd7;
      end
      imm_alu_pkg::SizeWord: begin
        mask_sz = 32'h0000_FFFF;
        msb_idx = 5'd15;
      end
      default: begin
        mask_sz = 32'hFFFF_FFFF;
        msb_idx = 5'd31;
      end
    endcase
  end

  // Shared adder: sized operands, or full width for quick ops to An
  always_comb begin
    mask_eff = (grp == imm_alu_pkg::GrpQuick && is_an) ? 32'hFFFF_FFFF : mask_sz;
    opa      = s1_q.dest_value & mask_eff;
    opb      = (grp == imm_alu_pkg::GrpQuick) ? {28'd0, q}
                                              : (s1_q.immediate_value & mask_sz);
    sub      = (grp == imm_alu_pkg::GrpQuick) ? op[8]
             : (high == imm_alu_pkg::OpSubi || high == imm_alu_pkg::OpCmpi);
    sum      = sub ? ({1'b0, opa} - {1'b0, opb}) : ({1'b0, opa} + {1'b0, opb});
    r_arith  = sum[31:0] & mask_eff;
    unique case (szf)
      imm_alu_pkg::SizeByte: c_flag = sum[8];
      imm_alu_pkg::SizeWord: c_flag = sum[16];
      default:               c_flag = sum[32];
    endcase
    vvec     = sub ? ((opa ^ opb) & (opa ^ r_arith)) : (~(opa ^ opb) & (opa ^ r_arith));
    v_flag   = vvec[msb_idx];
  end

  always_comb begin
    unique case (high)
      imm_alu_pkg::OpAndi: r_logic = opa & opb;
      imm_alu_pkg::OpEori: r_logic = opa ^ opb;
      default:             r_logic = opa | opb;
    endcase
    unique case (high)
      imm_alu_pkg::OpAndi: begin
        ccr_n = sr_q[4:0] & s1_q.immediate_value[4:0];
        sr_w  = sr_q & s1_q.immediate_value[15:0];
      end
      imm_alu_pkg::OpEori: begin
        ccr_n = sr_q[4:0] ^ s1_q.immediate_value[4:0];
        sr_w  = sr_q ^ s1_q.immediate_value[15:0];
      end
      default: begin
        ccr_n = sr_q[4:0] | s1_q.immediate_value[4:0];
        sr_w  = sr_q | s1_q.immediate_value[15:0];
      end
    endcase
  end

  always_comb begin
    rsp_d = '0;
    rsp_d.exec_status  = imm_alu_pkg::ExecOk;
    rsp_d.stack_switch = imm_alu_pkg::SwNone;
    sr_d  = sr_q;
    if (grp == imm_alu_pkg::GrpImm) begin
      if (op[8] || high == imm_alu_pkg::OpBitSt) begin
        rsp_d.exec_status = imm_alu_pkg::ExecNotHandled;
      end else if (op[7:0] == imm_alu_pkg::LowCcr || op[7:0] == imm_alu_pkg::LowSr) begin
        if (high != imm_alu_pkg::OpOri && high != imm_alu_pkg::OpAndi &&
            high != imm_alu_pkg::OpEori) begin
          rsp_d.exec_status = imm_alu_pkg::ExecIllegal;
        end else if (op[7:0] == imm_alu_pkg::LowCcr) begin
          sr_d = (sr_q & imm_alu_pkg::SrHighMask) | {11'd0, ccr_n & imm_alu_pkg::CcrMask};
          rsp_d.base_cycles = imm_alu_pkg::Cyc20;
        end else if (!sr_q[imm_alu_pkg::SrSBit]) begin
          rsp_d.exec_status = imm_alu_pkg::ExecPrivilege;
        end else begin
          sr_d = sr_w & imm_alu_pkg::SrImplMask;
          if (sr_q[imm_alu_pkg::SrSBit] && !sr_d[imm_alu_pkg::SrSBit]) begin
            rsp_d.stack_switch = imm_alu_pkg::SwUser;
          end else if (!sr_q[imm_alu_pkg::SrSBit] && sr_d[imm_alu_pkg::SrSBit]) begin
            rsp_d.stack_switch = imm_alu_pkg::SwSuper;
          end
          rsp_d.base_cycles = imm_alu_pkg::Cyc20;
        end
      end else if (high == imm_alu_pkg::OpUnused || szf == imm_alu_pkg::SizeNone ||
                   is_an || (mode == imm_alu_pkg::ModeSpecial && rg >= 3'd2)) begin
        rsp_d.exec_status = imm_alu_pkg::ExecIllegal;
      end else begin
        rsp_d.add_ea_cycles = (mode != imm_alu_pkg::ModeDataReg);
        if (high == imm_alu_pkg::OpOri || high == imm_alu_pkg::OpAndi ||
            high == imm_alu_pkg::OpEori) begin
          rsp_d.result_value = r_logic;
          sr_d[imm_alu_pkg::CcrN] = r_logic[msb_idx];
          sr_d[imm_alu_pkg::CcrZ] = (r_logic == 32'd0);
          sr_d[imm_alu_pkg::CcrV] = 1'b0;
          sr_d[imm_alu_pkg::CcrC] = 1'b0;
        end else begin
          rsp_d.result_value = r_arith;
          sr_d[imm_alu_pkg::CcrN] = r_arith[msb_idx];
          sr_d[imm_alu_pkg::CcrZ] = (r_arith == 32'd0);
          sr_d[imm_alu_pkg::CcrV] = v_flag;
          sr_d[imm_alu_pkg::CcrC] = c_flag;
          // CMPI leaves X alone
          if (high != imm_alu_pkg::OpCmpi) begin
            sr_d[imm_alu_pkg::CcrX] = c_flag;
          end
        end
        if (high == imm_alu_pkg::OpCmpi) begin
          rsp_d.base_cycles = (mode == imm_alu_pkg::ModeDataReg)
                            ? (lng ? imm_alu_pkg::Cyc14 : imm_alu_pkg::Cyc8)
                            : (lng ? imm_alu_pkg::Cyc12 : imm_alu_pkg::Cyc8);
        end else begin
          rsp_d.write_result = 1'b1;
          rsp_d.base_cycles  = (mode == imm_alu_pkg::ModeDataReg)
                             ? (lng ? imm_alu_pkg::Cyc16 : imm_alu_pkg::Cyc8)
                             : (lng ? imm_alu_pkg::Cyc20 : imm_alu_pkg::Cyc12);
        end
      end
    end else if (grp == imm_alu_pkg::GrpQuick) begin
      if (szf == imm_alu_pkg::SizeNone) begin
        rsp_d.exec_status = imm_alu_pkg::ExecNotHandled;
      end else if ((is_an && szf == imm_alu_pkg::SizeByte) ||
                   (mode == imm_alu_pkg::ModeSpecial && rg >= 3'd2)) begin
        rsp_d.exec_status = imm_alu_pkg::ExecIllegal;
      end else if (is_an) begin
        // Address register: full width, flags untouched
        rsp_d.result_value = r_arith;
        rsp_d.write_result = 1'b1;
        rsp_d.base_cycles  = imm_alu_pkg::Cyc8;
      end else begin
        rsp_d.result_value  = r_arith;
        rsp_d.write_result  = 1'b1;
        rsp_d.add_ea_cycles = (mode != imm_alu_pkg::ModeDataReg);
        sr_d[imm_alu_pkg::CcrN] = r_arith[msb_idx];
        sr_d[imm_alu_pkg::CcrZ] = (r_arith == 32'd0);
        sr_d[imm_alu_pkg::CcrV] = v_flag;
        sr_d[imm_alu_pkg::CcrC] = c_flag;
        sr_d[imm_alu_pkg::CcrX] = c_flag;
        rsp_d.base_cycles = (mode == imm_alu_pkg::ModeDataReg)
                          ? (lng ? imm_alu_pkg::Cyc8 : imm_alu_pkg::Cyc4)
                          : (lng ? imm_alu_pkg::Cyc12 : imm_alu_pkg::Cyc8);
      end
    end else begin
      rsp_d.exec_status = imm_alu_pkg::ExecNotHandled;
    end
    rsp_d.sr_out = sr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sr_q        <= imm_alu_pkg::SrReset;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_load) begin
        s1_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
      // Commit SR as the request leaves the execute register
      if (s1_load) begin
        sr_q <= sr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_req_i;
    end
    if (s1_load) begin
      out_rsp_q <= rsp_d;
    end
  end

`ifndef SYNTHESIS
  a_no_exec_keeps_sr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_load && rsp_d.exec_status != imm_alu_pkg::ExecOk |=> sr_q == $past(sr_q))
    else $error("SR changed by a request that did not execute");

  a_no_exec_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_load && rsp_d.exec_status != imm_alu_pkg::ExecOk |->
      rsp_d.result_value == 32'd0 && !rsp_d.write_result && rsp_d.base_cycles == 5'd0)
    else $error("non-executed request produced a result");

  a_user_switch_clears_s: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_load && rsp_d.stack_switch == imm_alu_pkg::SwUser |->
      !rsp_d.sr_out[imm_alu_pkg::SrSBit])
    else $error("user stack switch with S still set");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

  a_sr_out_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_load |=> out_rsp_q.sr_out == sr_q)
    else $error("reported SR differs from held SR");
`endif

endmodule
